// File: rtl/core/cicd_pkg.sv
`timescale 1ns / 1ps
package cicd_pkg;

    localparam int MAX_STAGES_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int ACC_W      = 64;
    localparam int HALF_W     = ACC_W / 2;
    localparam int DEC_W      = 13;
    localparam int PHASE_W    = 12;
    localparam int MAX_DECIM  = 4096;
    localparam int STG_W      = 4;
    localparam int GAIN_W     = 17;
    localparam int GSH_W      = 6;
    localparam int OUT_W      = 16;
    localparam int SHIFT_BASE = 16;
    localparam int SH_W       = 7;
    localparam int PART_W     = HALF_W + GAIN_W;
    localparam int PROD_W     = ACC_W + GAIN_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam int REG_AW  = 4;
    localparam int REG_IW  = 2;
    localparam int APB_DW  = 32;

    localparam logic [REG_IW-1:0] REG_DECIM  = 2'd0;
    localparam logic [REG_IW-1:0] REG_STAGES = 2'd1;
    localparam logic [REG_IW-1:0] REG_GAIN   = 2'd2;
    localparam logic [REG_IW-1:0] REG_GSHIFT = 2'd3;

    typedef logic [ACC_W-1:0] t_acc;

    typedef struct packed {
        t_acc re;
        t_acc im;
    } t_iq;

    // Effective settings: decimation and stage count already clamped
    typedef struct packed {
        logic [DEC_W-1:0]  decim;
        logic [STG_W-1:0]  stages;
        logic [GAIN_W-1:0] gain;
        logic [GSH_W-1:0]  gshift;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// File: rtl/core/cicd_front.sv
`timescale 1ns / 1ps
module cicd_front #(
    parameter int MAX_STAGES  = cicd_pkg::MAX_STAGES_DEF,
    parameter int SAMPLE_BITS = cicd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cicd_pkg::t_cfg         i_cfg,
    input  logic                   i_in_vld,
    input  logic [SAMPLE_BITS-1:0] i_re,
    input  logic [SAMPLE_BITS-1:0] i_im,
    output logic                   o_in_rdy,
    input  cicd_pkg::t_qstat       i_qstat,
    output logic                   o_push,
    output cicd_pkg::t_iq          o_push_data
);
    import cicd_pkg::*;

    localparam int LAST = MAX_STAGES - 1;

    logic [PHASE_W-1:0]    r_phase;
    logic [PHASE_W-1:0]    n_phase;
    logic                  w_emit;
    logic                  w_adv;

    logic [MAX_STAGES-1:0] r_vld;
    logic [MAX_STAGES-1:0] r_emit;
    t_acc                  r_val   [MAX_STAGES][2];
    t_acc                  r_integ [MAX_STAGES][2];

    logic [MAX_STAGES-1:0] w_in_vld;
    logic [MAX_STAGES-1:0] w_in_emit;
    logic [MAX_STAGES-1:0] w_act;
    t_acc                  w_in    [MAX_STAGES][2];
    t_acc                  w_sum   [MAX_STAGES][2];

    // Stall only when an output sample sits at the tail and the queue is full
    always_comb begin
        w_adv    = !(r_vld[LAST] && r_emit[LAST] && i_qstat.full);
        o_in_rdy = w_adv;
        w_emit   = (({1'b0, r_phase} + DEC_W'(1)) >= i_cfg.decim);
        n_phase  = w_emit ? '0 : r_phase + PHASE_W'(1);
    end

    always_comb begin
        for (int k = 0; k < MAX_STAGES; k++) begin
            if (k == 0) begin
                w_in_vld[k]  = i_in_vld;
                w_in_emit[k] = w_emit;
                w_in[k][0]   = {{(ACC_W-SAMPLE_BITS){i_re[SAMPLE_BITS-1]}}, i_re};
                w_in[k][1]   = {{(ACC_W-SAMPLE_BITS){i_im[SAMPLE_BITS-1]}}, i_im};
            end else begin
                w_in_vld[k]  = r_vld[k-1];
                w_in_emit[k] = r_emit[k-1];
                w_in[k][0]   = r_val[k-1][0];
                w_in[k][1]   = r_val[k-1][1];
            end
            w_act[k] = (STG_W'(k) < i_cfg.stages);
            for (int l = 0; l < 2; l++) begin
                w_sum[k][l] = w_in[k][l] + r_integ[k][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_phase <= '0;
            for (int k = 0; k < MAX_STAGES; k++) begin
                r_integ[k][0] <= '0;
                r_integ[k][1] <= '0;
            end
        end else if (w_adv) begin
            r_vld <= w_in_vld;
            if (i_in_vld) begin
                r_phase <= n_phase;
            end
            for (int k = 0; k < MAX_STAGES; k++) begin
                if (w_in_vld[k] && w_act[k]) begin
                    r_integ[k][0] <= w_sum[k][0];
                    r_integ[k][1] <= w_sum[k][1];
                end
            end
        end
    end

    // Pass the sum on through active stages, the raw value through idle ones
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_emit <= w_in_emit;
            for (int k = 0; k < MAX_STAGES; k++) begin
                for (int l = 0; l < 2; l++) begin
                    r_val[k][l] <= w_act[k] ? w_sum[k][l] : w_in[k][l];
                end
            end
        end
    end

    assign o_push         = r_vld[LAST] && r_emit[LAST] && !i_qstat.full;
    assign o_push_data.re = r_val[LAST][0];
    assign o_push_data.im = r_val[LAST][1];

endmodule

// File: rtl/core/cicd_fifo.sv
`timescale 1ns / 1ps
module cicd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cicd_pkg::t_iq    i_push_data,
    input  logic             i_pop,
    output cicd_pkg::t_iq    o_pop_data,
    output cicd_pkg::t_qstat o_qstat
);
    import cicd_pkg::*;

    t_iq                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            r_cnt <= r_cnt + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_pop_data    = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_qstat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_qstat.empty)
        else $error("pop from empty queue");

    a_cnt_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not follow push");
`endif

endmodule

// File: rtl/core/cicd_back.sv
`timescale 1ns / 1ps
module cicd_back #(
    parameter int MAX_STAGES = cicd_pkg::MAX_STAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cicd_pkg::t_cfg              i_cfg,
    input  cicd_pkg::t_qstat            i_qstat,
    input  cicd_pkg::t_iq               i_pop_data,
    output logic                        o_pop,
    output logic                        o_out_vld,
    input  logic                        i_out_rdy,
    output logic [cicd_pkg::OUT_W-1:0]  o_out_re,
    output logic [cicd_pkg::OUT_W-1:0]  o_out_im
);
    import cicd_pkg::*;

    localparam int LAST = MAX_STAGES - 1;
    localparam int QL_W = OUT_W - 1;

    logic                  w_adv;

    // comb cascade
    logic [MAX_STAGES-1:0] r_cvld;
    t_acc                  r_cval [MAX_STAGES][2];
    t_acc                  r_cdly [MAX_STAGES][2];
    logic [MAX_STAGES-1:0] w_cin_vld;
    logic [MAX_STAGES-1:0] w_act;
    t_acc                  w_cin  [MAX_STAGES][2];
    t_acc                  w_diff [MAX_STAGES][2];

    // scaling pipeline
    logic                  r_mvld, r_pvld, r_svld, r_qvld, r_ovld;
    logic [1:0]            r_neg_m, r_neg_p, r_neg_s, r_neg_q;
    t_acc                  r_mag  [2];
    logic [PART_W-1:0]     r_p0   [2];
    logic [PART_W-1:0]     r_p1   [2];
    logic [PROD_W-1:0]     r_prod [2];
    logic [1:0]            r_big;
    logic [1:0]            r_rem;
    logic [QL_W-1:0]       r_ql   [2];
    logic [OUT_W-1:0]      r_out  [2];

    logic [SH_W-1:0]       w_sh;
    logic [PROD_W-1:0]     w_q    [2];
    logic [PROD_W-1:0]     w_mask;
    logic [OUT_W-1:0]      n_out  [2];

    always_comb begin
        w_adv = !r_ovld || i_out_rdy;
        o_pop = w_adv && !i_qstat.empty;
    end

    always_comb begin
        for (int k = 0; k < MAX_STAGES; k++) begin
            if (k == 0) begin
                w_cin_vld[k] = !i_qstat.empty;
                w_cin[k][0]  = i_pop_data.re;
                w_cin[k][1]  = i_pop_data.im;
            end else begin
                w_cin_vld[k] = r_cvld[k-1];
                w_cin[k][0]  = r_cval[k-1][0];
                w_cin[k][1]  = r_cval[k-1][1];
            end
            w_act[k] = (STG_W'(k) < i_cfg.stages);
            for (int l = 0; l < 2; l++) begin
                w_diff[k][l] = w_cin[k][l] - r_cdly[k][l];
            end
        end
    end

    // Floor shift with remainder, then saturate to 16 bits
    always_comb begin
        w_sh   = SH_W'(SHIFT_BASE) + SH_W'(i_cfg.gshift);
        w_mask = ~({PROD_W{1'b1}} << w_sh);
        for (int l = 0; l < 2; l++) begin
            w_q[l] = r_prod[l] >> w_sh;
            if (!r_neg_q[l]) begin
                n_out[l] = r_big[l] ? {1'b0, {QL_W{1'b1}}} : {1'b0, r_ql[l]};
            end else if (r_big[l] || ((&r_ql[l]) && r_rem[l])) begin
                n_out[l] = {1'b1, {QL_W{1'b0}}};
            end else begin
                n_out[l] = OUT_W'(0) - ({1'b0, r_ql[l]} + OUT_W'(r_rem[l]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= '0;
            r_mvld <= 1'b0;
            r_pvld <= 1'b0;
            r_svld <= 1'b0;
            r_qvld <= 1'b0;
            r_ovld <= 1'b0;
            for (int k = 0; k < MAX_STAGES; k++) begin
                r_cdly[k][0] <= '0;
                r_cdly[k][1] <= '0;
            end
        end else if (w_adv) begin
            r_cvld <= w_cin_vld;
            r_mvld <= r_cvld[LAST];
            r_pvld <= r_mvld;
            r_svld <= r_pvld;
            r_qvld <= r_svld;
            r_ovld <= r_qvld;
            for (int k = 0; k < MAX_STAGES; k++) begin
                if (w_cin_vld[k] && w_act[k]) begin
                    r_cdly[k][0] <= w_cin[k][0];
                    r_cdly[k][1] <= w_cin[k][1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < MAX_STAGES; k++) begin
                for (int l = 0; l < 2; l++) begin
                    r_cval[k][l] <= w_act[k] ? w_diff[k][l] : w_cin[k][l];
                end
            end
            for (int l = 0; l < 2; l++) begin
                // sign and magnitude
                r_neg_m[l] <= r_cval[LAST][l][ACC_W-1];
                r_mag[l]   <= r_cval[LAST][l][ACC_W-1] ? t_acc'(0) - r_cval[LAST][l]
                                                      : r_cval[LAST][l];
                // two partial products of the 32-bit halves and the gain
                r_neg_p[l] <= r_neg_m[l];
                r_p0[l]    <= PART_W'(r_mag[l][HALF_W-1:0]) * PART_W'(i_cfg.gain);
                r_p1[l]    <= PART_W'(r_mag[l][ACC_W-1:HALF_W]) * PART_W'(i_cfg.gain);
                // full product
                r_neg_s[l] <= r_neg_p[l];
                r_prod[l]  <= PROD_W'(r_p0[l]) + (PROD_W'(r_p1[l]) << HALF_W);
                // quotient and sticky remainder, then the saturated output
                r_neg_q[l] <= r_neg_s[l];
                r_big[l]   <= |w_q[l][PROD_W-1:QL_W];
                r_ql[l]    <= w_q[l][QL_W-1:0];
                r_rem[l]   <= |(r_prod[l] & w_mask);
                r_out[l]   <= n_out[l];
            end
        end
    end

    assign o_out_vld = r_ovld;
    assign o_out_re  = r_out[0];
    assign o_out_im  = r_out[1];

endmodule

// File: rtl/core/cic_decimator_complex_top.sv
`timescale 1ns / 1ps
// Complex CIC decimator: takes one I/Q sample (sample_re in tdata[15:0], sample_im in
// tdata[31:16], Q1.15) per clock and runs each part through an integrator cascade of
// active_stages 64-bit wrapping stages; every decimation_factor-th sample passes a comb
// cascade of equal length and is scaled by gain_coef / 2^(16 + gain_shift), floored
// and saturated to 16 bits. Sustained rate is one sample per cycle; the input only
// stalls when the output side backs up far enough to fill the four-entry result queue.
// Each sample passes MAX_STAGES pipelined integrators (one register per stage), the
// queue, then MAX_STAGES comb stages and registered steps for magnitude, split 32x17
// multiply, product add, shift and saturation. The block settles from reset at once;
// no clearing pass is needed.
// Registers (APB, byte address 4*i): 0 decimation_factor, 1 active_stages,
// 2 gain_coef, 3 gain_shift. Write them only while the block is idle.
module cic_decimator_complex_top #(
    parameter int MAX_STAGES  = cicd_pkg::MAX_STAGES_DEF,
    parameter int SAMPLE_BITS = cicd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input sample stream
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     i_s_tdata,   // sample_re, sample_im
    // decimated output stream
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [2*cicd_pkg::OUT_W-1:0]           o_m_tdata,   // out_re, out_im
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [cicd_pkg::REG_AW-1:0]            paddr,
    input  logic [cicd_pkg::APB_DW-1:0]            pwdata,
    output logic [cicd_pkg::APB_DW-1:0]            prdata,
    output logic                                   pready
);
    import cicd_pkg::*;

    logic [DEC_W-1:0]  r_decim;
    logic [STG_W-1:0]  r_stages;
    logic [GAIN_W-1:0] r_gain;
    logic [GSH_W-1:0]  r_gshift;

    logic [REG_IW-1:0] w_idx;
    logic              w_wr;
    t_cfg              w_cfg;

    logic              w_push;
    logic              w_pop;
    t_iq               w_push_data;
    t_iq               w_pop_data;
    t_qstat            w_qstat;
    logic [OUT_W-1:0]  w_out_re;
    logic [OUT_W-1:0]  w_out_im;

    assign pready = 1'b1;
    assign w_idx  = paddr[REG_AW-1:REG_AW-REG_IW];
    assign w_wr   = psel && penable && pwrite;

    // Register write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decim  <= DEC_W'(8);
            r_stages <= STG_W'(4);
            r_gain   <= GAIN_W'(65536);
            r_gshift <= GSH_W'(12);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DECIM:  r_decim  <= pwdata[DEC_W-1:0];
                REG_STAGES: r_stages <= pwdata[STG_W-1:0];
                REG_GAIN:   r_gain   <= pwdata[GAIN_W-1:0];
                REG_GSHIFT: r_gshift <= pwdata[GSH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DECIM:  prdata = APB_DW'(r_decim);
            REG_STAGES: prdata = APB_DW'(r_stages);
            REG_GAIN:   prdata = APB_DW'(r_gain);
            REG_GSHIFT: prdata = APB_DW'(r_gshift);
            default:    prdata = '0;
        endcase
    end

    // Clamp factor to 1..4096 and stage count to 1..MAX_STAGES
    always_comb begin
        if (r_decim == '0) begin
            w_cfg.decim = DEC_W'(1);
        end else if (r_decim > DEC_W'(MAX_DECIM)) begin
            w_cfg.decim = DEC_W'(MAX_DECIM);
        end else begin
            w_cfg.decim = r_decim;
        end
        if (r_stages == '0) begin
            w_cfg.stages = STG_W'(1);
        end else if (int'(r_stages) > MAX_STAGES) begin
            w_cfg.stages = STG_W'(MAX_STAGES);
        end else begin
            w_cfg.stages = r_stages;
        end
        w_cfg.gain   = r_gain;
        w_cfg.gshift = r_gshift;
    end

    cicd_front #(
        .MAX_STAGES  (MAX_STAGES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_vld    (i_s_tvalid),
        .i_re        (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_im        (i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .o_in_rdy    (o_s_tready),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    cicd_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_qstat     (w_qstat)
    );

    cicd_back #(
        .MAX_STAGES (MAX_STAGES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_qstat    (w_qstat),
        .i_pop_data (w_pop_data),
        .o_pop      (w_pop),
        .o_out_vld  (o_m_tvalid),
        .i_out_rdy  (i_m_tready),
        .o_out_re   (w_out_re),
        .o_out_im   (w_out_im)
    );

    assign o_m_tdata = {w_out_im, w_out_re};

endmodule

// File: tb/tb_cic_decimator_complex_top.sv
`timescale 1ns / 1ps
module tb_cic_decimator_complex_top;
    import cicd_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 40;   // well beyond the pipeline depth
    localparam int HOLD_CYCLES   = 300;  // long output stall for the pressure test
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_STAGES    = 8;

    typedef struct {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
    } t_iq_out;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [31:0]       s_tdata = '0;
    logic              o_s_tready;
    logic              o_m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       o_m_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [REG_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Register shadow used by the model
    logic [DEC_W-1:0]  cfg_decim;
    logic [STG_W-1:0]  cfg_stages;
    logic [GAIN_W-1:0] cfg_gain;
    logic [GSH_W-1:0]  cfg_gshift;

    // Model state: integrators, comb delays and frame position
    logic [ACC_W-1:0]   integ_re [NUM_STAGES];
    logic [ACC_W-1:0]   integ_im [NUM_STAGES];
    logic [ACC_W-1:0]   comb_re  [NUM_STAGES];
    logic [ACC_W-1:0]   comb_im  [NUM_STAGES];
    logic [PHASE_W-1:0] frame_pos;

    t_iq_out pending_iq[$];

    bit idle_en = 1'b0;
    bit hold_req = 1'b0;
    int mismatches = 0;
    int samples_sent = 0;
    int outputs_seen = 0;
    int settings_used = 0;

    cic_decimator_complex_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),      // [15:0] sample_re, [31:16] sample_im
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),    // [15:0] out_re, [31:16] out_im
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------
    task automatic clear_model();
        cfg_decim  = DEC_W'(8);
        cfg_stages = STG_W'(4);
        cfg_gain   = GAIN_W'(65536);
        cfg_gshift = GSH_W'(12);
        for (int k = 0; k < NUM_STAGES; k++) begin
            integ_re[k] = '0;
            integ_im[k] = '0;
            comb_re[k]  = '0;
            comb_im[k]  = '0;
        end
        frame_pos = '0;
    endtask

    // floor(v * gain / 2^(16 + shift)) clamped to 16 bits; the arithmetic
    // shift of the signed product rounds toward minus infinity
    function automatic logic signed [OUT_W-1:0] gain_and_saturate(input logic [ACC_W-1:0] v);
        logic signed [PROD_W:0] prod;
        logic signed [PROD_W:0] quo;
        prod = $signed(v) * $signed({1'b0, cfg_gain});
        quo  = prod >>> (SHIFT_BASE + cfg_gshift);
        if (quo > 32767)
            return 16'sh7FFF;
        if (quo < -32768)
            return 16'sh8000;
        return quo[OUT_W-1:0];
    endfunction

    // Run one accepted sample through the cascade; queue the result at frame end
    function automatic void decimate_iq(input logic signed [15:0] x_re,
                                        input logic signed [15:0] x_im);
        int               factor;
        int               nstg;
        logic [ACC_W-1:0] v_re;
        logic [ACC_W-1:0] v_im;
        logic [ACC_W-1:0] d_re;
        logic [ACC_W-1:0] d_im;
        t_iq_out          res;
        factor = (cfg_decim == 0) ? 1 : ((cfg_decim > MAX_DECIM) ? MAX_DECIM : int'(cfg_decim));
        nstg   = (cfg_stages == 0) ? 1 :
                 ((cfg_stages > NUM_STAGES) ? NUM_STAGES : int'(cfg_stages));
        v_re = {{(ACC_W-16){x_re[15]}}, x_re};
        v_im = {{(ACC_W-16){x_im[15]}}, x_im};
        for (int k = 0; k < nstg; k++) begin
            v_re = v_re + integ_re[k];
            v_im = v_im + integ_im[k];
            integ_re[k] = v_re;
            integ_im[k] = v_im;
        end
        if (int'(frame_pos) + 1 < factor) begin
            frame_pos = frame_pos + 1'b1;
            return;
        end
        frame_pos = '0;
        for (int k = 0; k < nstg; k++) begin
            d_re = v_re - comb_re[k];
            d_im = v_im - comb_im[k];
            comb_re[k] = v_re;
            comb_im[k] = v_im;
            v_re = d_re;
            v_im = d_im;
        end
        res.re = gain_and_saturate(v_re);
        res.im = gain_and_saturate(v_im);
        pending_iq.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Bus helpers
    // ------------------------------------------------------------------
    // APB write: setup cycle, access cycle until pready, then return to idle
    task automatic write_reg(input logic [REG_IW-1:0] idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_DECIM:  cfg_decim  = val[DEC_W-1:0];
            REG_STAGES: cfg_stages = val[STG_W-1:0];
            REG_GAIN:   cfg_gain   = val[GAIN_W-1:0];
            REG_GSHIFT: cfg_gshift = val[GSH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input int decim, input int stages, input int gain,
                                 input int gshift);
        write_reg(REG_DECIM, decim);
        write_reg(REG_STAGES, stages);
        write_reg(REG_GAIN, gain);
        write_reg(REG_GSHIFT, gshift);
        settings_used++;
    endtask

    // Offer one sample, optionally after a random gap; hold until accepted
    task automatic send_iq(input logic signed [15:0] x_re, input logic signed [15:0] x_im);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {x_im, x_re};
        do @(posedge i_clk); while (!o_s_tready);
        decimate_iq(x_re, x_im);
        samples_sent++;
    endtask

    // Drop valid, wait for every queued result, then let the pipeline drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_iq.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly uniform, sometimes a full-scale or near-zero corner
    function automatic logic signed [15:0] rand_part();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 4)) - 2);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++)
            send_iq(rand_part(), rand_part());
    endtask

    // ------------------------------------------------------------------
    // Output monitor: checks results, owns tready and its stalls
    // ------------------------------------------------------------------
    task automatic check_output(input logic [31:0] data);
        t_iq_out want;
        t_iq_out got;
        got.re = data[15:0];
        got.im = data[31:16];
        outputs_seen++;
        if (pending_iq.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] unexpected output re=%0d im=%0d", $time, got.re, got.im);
            return;
        end
        want = pending_iq.pop_front();
        if (got.re !== want.re || got.im !== want.im) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] output mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
                         $time, want.re, want.im, got.re, got.im);
        end
    endtask

    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && m_tready)
                check_output(o_m_tdata);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset settings (factor 8, four stages) with full-scale corner samples
    task automatic test_reset_settings();
        send_iq(16'sh7FFF, 16'sh8000);
        send_iq(16'sh8000, 16'sh7FFF);
        send_iq(16'sh0000, 16'sh0000);
        send_iq(16'shFFFF, 16'sh0001);
        send_iq(16'sh5555, 16'shAAAA);
        send_iq(16'shAAAA, 16'sh5555);
        send_iq(16'sh7FFF, 16'sh7FFF);
        send_iq(16'sh8000, 16'sh8000);
        settle();
    endtask

    // Factor and stage count of zero act as one: output follows input
    task automatic test_zero_clamps();
        load_settings(0, 0, 65536, 0);
        send_iq(16'sh7FFF, 16'sh8000);
        send_iq(16'sh8000, 16'sh7FFF);
        send_iq(16'sh0001, 16'shFFFF);
        send_iq(16'sh0000, 16'sh0000);
        settle();
    endtask

    // Stage count above eight clamps; drive the gain to its extremes
    task automatic test_gain_extremes();
        load_settings(1, 15, 131071, 0);
        send_iq(16'sh7FFF, 16'sh8000);
        send_iq(16'sh8000, 16'sh7FFF);
        send_iq(16'sh1234, 16'shEDCB);
        settle();
        write_reg(REG_GAIN, 0);
        send_iq(16'sh7FFF, 16'sh8000);
        send_iq(16'sh8000, 16'sh0001);
        settle();
        load_settings(1, 8, 131071, 63);
        send_iq(16'sh7FFF, 16'sh8000);
        send_iq(16'sh8000, 16'sh7FFF);
        settle();
    endtask

    // Lower the factor below the current frame position: next sample ends the frame
    task automatic test_factor_lowered();
        load_settings(8, 4, 65536, 12);
        send_random(13);
        settle();
        write_reg(REG_DECIM, 3);
        send_random(7);
        settle();
    endtask

    // Unused stages must keep their contents across stage-count changes
    task automatic test_stage_change();
        load_settings(4, 2, 65536, 4);
        send_random(12);
        settle();
        load_settings(4, 6, 65536, 12);
        send_random(12);
        settle();
        load_settings(4, 2, 65536, 4);
        send_random(12);
        settle();
    endtask

    // Largest factor written directly, then a factor above the limit; the frame
    // position carries into the next settings
    task automatic test_largest_factor();
        load_settings(4096, 3, 65536, 36);
        send_random(30);
        settle();
        write_reg(REG_DECIM, 8191);
        send_random(30);
        settle();
    endtask

    // Stall the output long enough to fill the result queue and back up the input,
    // then pause the input until every result is out
    task automatic test_backpressure();
        idle_en = 1'b0;
        load_settings(1, 2, 65536, 0);
        hold_req = 1'b1;
        send_random(80);
        settle();
        idle_en = 1'b1;
    endtask

    // Random settings, random data; the final phases run without idling
    task automatic test_random_settings(input int phases, input int per_phase);
        int decim;
        int stages;
        int growth;
        int gshift;
        for (int p = 0; p < phases; p++) begin
            idle_en = (p < phases - 2);
            decim  = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            stages = $urandom_range(1, 8);
            growth = stages * $clog2(decim);
            gshift = growth + int'($urandom_range(0, 3)) - 1;
            if ($urandom_range(0, 5) == 0)
                gshift = $urandom_range(0, 63);
            if (gshift < 0)
                gshift = 0;
            if (gshift > 63)
                gshift = 63;
            load_settings(decim, stages, $urandom_range(0, 131071), gshift);
            send_random(per_phase);
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_en = 1'b1;

        test_reset_settings();
        test_zero_clamps();
        test_gain_extremes();
        test_factor_lowered();
        test_stage_change();
        test_largest_factor();
        test_backpressure();
        test_random_settings(8, 50);

        idle_en = 1'b0;
        settle();

        $display("covered %0d samples and %0d decimated outputs over %0d register settings",
                 samples_sent, outputs_seen, settings_used);
        $display("full frames at factors up to 64, partial frames at 4096 and above, 1..8 stages, gain and shift extremes");
        if (mismatches == 0 && pending_iq.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d outputs never arrived", mismatches, pending_iq.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
